/* hw/rtl/hcw_pkg.sv */
package hcw_pkg;

	localparam int ENTRIES_DEF      = 384;
	localparam int EVICT_WINDOW_DEF = 8;

	// home slot hash multipliers
	localparam int HASH_MUL_F = 7919;
	localparam int HASH_MUL_S = 131;

	localparam int KEY_W  = 30;
	localparam int AGE_W  = 32;
	localparam int SLOT_W = 9;
	// font*7919 + size*131 + code stays below 2^22
	localparam int SUM_W  = 22;
	// hash phases: quotient, product, remainder
	localparam int HCNT_W = 2;

	typedef struct packed {
		logic        font_select;
		logic [7:0]  pixel_size;
		logic [20:0] code_point;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot_index;
		logic              evicted;
	} rsp_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [AGE_W-1:0] age;
	} slot_entry_t;

	typedef struct packed {
		logic             lt;
		logic [AGE_W-1:0] diff;
	} cmp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_PROBE_RD,
		ST_PROBE_CHK,
		ST_WIN_RD,
		ST_WIN_CHK,
		ST_FILL
	} state_t;

endpackage

/* hw/rtl/hcw_cmp_sub.sv */
module hcw_cmp_sub (
	input  logic [hcw_pkg::AGE_W-1:0] a,
	input  logic [hcw_pkg::AGE_W-1:0] b,
	output hcw_pkg::cmp_t             res
);

	logic [hcw_pkg::AGE_W:0] d;

	assign d        = {1'b0, a} - {1'b0, b};
	assign res.lt   = d[hcw_pkg::AGE_W];
	assign res.diff = d[hcw_pkg::AGE_W-1:0];

endmodule

/* hw/rtl/hcw_slot_ram.sv */
module hcw_slot_ram #(
	parameter int DEPTH = hcw_pkg::ENTRIES_DEF,
	parameter int AW    = $clog2(hcw_pkg::ENTRIES_DEF)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  hcw_pkg::slot_entry_t  wdata,
	input  logic [AW-1:0]         raddr,
	output hcw_pkg::slot_entry_t  rdata
);

	hcw_pkg::slot_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/hashed_tag_cache_window_lru.sv */
// Glyph tag cache: start with a key while busy is low; exactly one result
// follows on rsp, flagged by done for a single cycle, and the receiver cannot
// stall it. After reset the block sweeps every slot once to clear it, and busy
// stays high while it does. The home slot of an item comes from a reciprocal
// multiply for the quotient, a multiply back by ENTRIES and the remainder
// subtract in the shared compare/subtract unit; each slot probed then takes
// one read of the slot memory and one check, and on a miss each slot of the
// replacement window takes a read and a check too, followed by one fill. The
// result appears the cycle after the hit check or the fill, as busy falls.
module hashed_tag_cache_window_lru #(
	parameter int ENTRIES      = hcw_pkg::ENTRIES_DEF,
	parameter int EVICT_WINDOW = hcw_pkg::EVICT_WINDOW_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  hcw_pkg::req_t req,
	output logic          done,
	output hcw_pkg::rsp_t rsp
);

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int WCNT_W = (EVICT_WINDOW > 1) ? $clog2(EVICT_WINDOW) : 1;
	localparam int SUM_W  = hcw_pkg::SUM_W;
	localparam int HCNT_W = hcw_pkg::HCNT_W;
	localparam int AGE_W  = hcw_pkg::AGE_W;
	// floor(sum / ENTRIES) = (sum * RCP_M) >> RCP_SH for every sum below 2^SUM_W
	localparam int RCP_SH = SUM_W + $clog2(ENTRIES);
	localparam int PROD_W = SUM_W + RCP_SH;
	localparam longint unsigned RCP_M =
		((64'd1 << RCP_SH) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES);

	hcw_pkg::state_t state_q, state_d;

	logic [IDX_W-1:0]         clr_q;
	logic [IDX_W-1:0]         ptr_q;
	logic [IDX_W-1:0]         home_q;
	logic [IDX_W-1:0]         pcnt_q;
	logic [IDX_W-1:0]         victim_q;
	logic [IDX_W-1:0]         r_next;
	logic [IDX_W-1:0]         ptr_inc;
	logic [WCNT_W-1:0]        wcnt_q;
	logic [HCNT_W-1:0]        hcnt_q;
	logic [SUM_W-1:0]         sum_q;
	logic [SUM_W-1:0]         sum_d;
	logic [SUM_W-1:0]         div_q;
	logic [PROD_W-1:0]        quo_full;
	logic [hcw_pkg::KEY_W-1:0] key_q;
	logic [AGE_W-1:0]         best_q;
	logic [AGE_W-1:0]         tick_q;
	logic                     ev_q;
	logic                     done_q;
	hcw_pkg::rsp_t            rsp_q;

	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	logic [IDX_W-1:0]     mem_raddr;
	hcw_pkg::slot_entry_t mem_wdata;
	hcw_pkg::slot_entry_t mem_rdata;

	logic [AGE_W-1:0] alu_a;
	logic [AGE_W-1:0] alu_b;
	hcw_pkg::cmp_t    alu_res;

	logic key_match;
	logic last_probe;
	logic last_win;
	logic item_done;

	hcw_slot_ram #(
		.DEPTH (ENTRIES),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	hcw_cmp_sub u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	assign sum_d = (req.font_select ? SUM_W'(hcw_pkg::HASH_MUL_F) : '0)
		+ SUM_W'(req.pixel_size) * SUM_W'(hcw_pkg::HASH_MUL_S)
		+ SUM_W'(req.code_point);

	assign quo_full = PROD_W'(sum_q) * PROD_W'(RCP_M);

	// remainder: hash sum minus quotient times ENTRIES; else slot age against the oldest age
	always_comb begin
		if (state_q == hcw_pkg::ST_HASH) begin
			alu_a = AGE_W'(sum_q);
			alu_b = AGE_W'(div_q);
		end else begin
			alu_a = mem_rdata.age;
			alu_b = best_q;
		end
	end

	assign r_next     = alu_res.diff[IDX_W-1:0];
	assign ptr_inc    = (ptr_q == IDX_W'(ENTRIES - 1)) ? '0 : ptr_q + 1'b1;
	assign key_match  = mem_rdata.key == key_q;
	assign last_probe = pcnt_q == IDX_W'(ENTRIES - 1);
	assign last_win   = wcnt_q == WCNT_W'(EVICT_WINDOW - 1);
	assign item_done  = (state_q == hcw_pkg::ST_PROBE_CHK && mem_rdata.valid && key_match)
		|| state_q == hcw_pkg::ST_FILL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hcw_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = '{valid: 1'b1, key: key_q, age: tick_q + 1'b1};
		mem_raddr = ptr_q;
		case (state_q)
			hcw_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == IDX_W'(ENTRIES - 1)) begin
					state_d = hcw_pkg::ST_IDLE;
				end
			end
			hcw_pkg::ST_IDLE: begin
				if (start) begin
					state_d = hcw_pkg::ST_HASH;
				end
			end
			hcw_pkg::ST_HASH: begin
				if (hcnt_q == '0) begin
					state_d = hcw_pkg::ST_PROBE_RD;
				end
			end
			hcw_pkg::ST_PROBE_RD: begin
				state_d = hcw_pkg::ST_PROBE_CHK;
			end
			hcw_pkg::ST_PROBE_CHK: begin
				if (mem_rdata.valid && key_match) begin
					mem_we  = 1'b1;
					state_d = hcw_pkg::ST_IDLE;
				end else if (!mem_rdata.valid || last_probe) begin
					state_d = hcw_pkg::ST_WIN_RD;
				end else begin
					state_d = hcw_pkg::ST_PROBE_RD;
				end
			end
			hcw_pkg::ST_WIN_RD: begin
				state_d = hcw_pkg::ST_WIN_CHK;
			end
			hcw_pkg::ST_WIN_CHK: begin
				if (!mem_rdata.valid || last_win) begin
					state_d = hcw_pkg::ST_FILL;
				end else begin
					state_d = hcw_pkg::ST_WIN_RD;
				end
			end
			hcw_pkg::ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = victim_q;
				state_d   = hcw_pkg::ST_IDLE;
			end
			default: begin
				state_d = hcw_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			tick_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= item_done;
			if (state_q == hcw_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (item_done) begin
				tick_q <= tick_q + 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			hcw_pkg::ST_IDLE: begin
				key_q  <= req;
				sum_q  <= sum_d;
				hcnt_q <= HCNT_W'(2);
			end
			hcw_pkg::ST_HASH: begin
				hcnt_q <= hcnt_q - 1'b1;
				if (hcnt_q == HCNT_W'(2)) begin
					div_q <= quo_full[PROD_W-1:RCP_SH];
				end else if (hcnt_q == HCNT_W'(1)) begin
					div_q <= div_q * SUM_W'(ENTRIES);
				end else begin
					home_q <= r_next;
					ptr_q  <= r_next;
					pcnt_q <= '0;
				end
			end
			hcw_pkg::ST_PROBE_CHK: begin
				if (mem_rdata.valid && key_match) begin
					rsp_q <= '{hit: 1'b1, slot_index: hcw_pkg::SLOT_W'(ptr_q),
						evicted: 1'b0};
				end else if (!mem_rdata.valid || last_probe) begin
					ptr_q    <= home_q;
					victim_q <= home_q;
					wcnt_q   <= '0;
				end else begin
					ptr_q  <= ptr_inc;
					pcnt_q <= pcnt_q + 1'b1;
				end
			end
			hcw_pkg::ST_WIN_CHK: begin
				if (!mem_rdata.valid) begin
					victim_q <= ptr_q;
					ev_q     <= 1'b0;
				end else begin
					// first window slot is home: seed the oldest age
					if (wcnt_q == '0) begin
						best_q <= mem_rdata.age;
					end else if (alu_res.lt) begin
						best_q   <= mem_rdata.age;
						victim_q <= ptr_q;
					end
					ev_q   <= 1'b1;
					wcnt_q <= wcnt_q + 1'b1;
					ptr_q  <= ptr_inc;
				end
			end
			hcw_pkg::ST_FILL: begin
				rsp_q <= '{hit: 1'b0, slot_index: hcw_pkg::SLOT_W'(victim_q),
					evicted: ev_q};
			end
			default: begin
			end
		endcase
	end

	assign busy = state_q != hcw_pkg::ST_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy) && !$past(done_q))
		else $error("result strobe not preceded by a busy item");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && rsp_q.hit |-> !rsp_q.evicted)
		else $error("hit reported an eviction");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hcw_pkg::ST_PROBE_RD || state_q == hcw_pkg::ST_WIN_RD
		|-> 32'(ptr_q) < ENTRIES)
		else $error("probe pointer beyond table");

	a_victim_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hcw_pkg::ST_FILL |-> 32'(victim_q) < ENTRIES)
		else $error("victim slot beyond table");

endmodule

/* bench/hashed_tag_cache_window_lru_tb.sv */
module hashed_tag_cache_window_lru_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES       = hcw_pkg::ENTRIES_DEF;
	localparam int WINDOW        = hcw_pkg::EVICT_WINDOW_DEF;
	localparam int MUL_FONT      = 7919;
	localparam int MUL_SIZE      = 131;
	localparam int KEY_HISTORY   = 64;
	localparam int IDLE_LIMIT    = 5000;
	// worst case lookup: hash, full probe of the table, window scan, fill
	localparam int DRAIN_CYCLES  = 900;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	hcw_pkg::req_t req = '0;
	logic done;
	hcw_pkg::rsp_t rsp;

	hashed_tag_cache_window_lru dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// shadow of the tag table
	bit          tag_valid [ENTRIES];
	bit [29:0]   tag_store [ENTRIES];
	bit [31:0]   tag_age [ENTRIES];
	bit [31:0]   use_tick;

	hcw_pkg::rsp_t expected_rsp [$];
	hcw_pkg::req_t sent_keys [$];
	int   mismatches = 0;
	int   idle_cycles = 0;
	bit   no_gaps = 1'b0;

	function automatic hcw_pkg::rsp_t lookup_key(input hcw_pkg::req_t item);
		bit [29:0] tag;
		int home;
		int p;
		int victim;
		hcw_pkg::rsp_t r;
		tag = item;
		home = (int'(item.font_select) * MUL_FONT + int'(item.pixel_size) * MUL_SIZE
			+ int'(item.code_point)) % ENTRIES;
		for (int i = 0; i < ENTRIES; i++) begin
			p = (home + i) % ENTRIES;
			if (!tag_valid[p])
				break;
			if (tag_store[p] == tag) begin
				use_tick++;
				tag_age[p] = use_tick;
				r.hit = 1'b1;
				r.slot_index = hcw_pkg::SLOT_W'(p);
				r.evicted = 1'b0;
				return r;
			end
		end
		// victim: first empty slot in the window, else strictly oldest
		victim = home;
		for (int i = 0; i < WINDOW; i++) begin
			p = (home + i) % ENTRIES;
			if (!tag_valid[p]) begin
				victim = p;
				break;
			end
			if (tag_age[p] < tag_age[victim])
				victim = p;
		end
		r.hit = 1'b0;
		r.slot_index = hcw_pkg::SLOT_W'(victim);
		r.evicted = tag_valid[victim];
		use_tick++;
		tag_valid[victim] = 1'b1;
		tag_store[victim] = tag;
		tag_age[victim] = use_tick;
		return r;
	endfunction

	// key whose home slot is the given one; k picks among the aliases
	function automatic hcw_pkg::req_t make_key(input bit f, input bit [7:0] s,
			input int home, input int k);
		int r;
		hcw_pkg::req_t item;
		r = (home - int'(f) * MUL_FONT - int'(s) * MUL_SIZE) % ENTRIES;
		if (r < 0)
			r += ENTRIES;
		item.font_select = f;
		item.pixel_size = s;
		item.code_point = 21'(r + ENTRIES * k);
		return item;
	endfunction

	function automatic hcw_pkg::req_t pick_key();
		int hot [7] = '{0, 1, 2, 191, 381, 382, 383};
		int choice;
		hcw_pkg::req_t item;
		choice = $urandom_range(0, 99);
		if (choice < 35 && sent_keys.size() != 0) begin
			item = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
		end else if (choice < 70) begin
			item = make_key(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
				hot[$urandom_range(0, 6)], int'($urandom_range(0, 5460)));
		end else begin
			item.font_select = 1'($urandom_range(0, 1));
			item.pixel_size = 8'($urandom_range(0, 255));
			item.code_point = 21'($urandom_range(0, 2097151));
		end
		return item;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
	endtask

	// called at a rising edge; returns at the edge that accepts the item
	task automatic send_key(input hcw_pkg::req_t item);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		repeat (gap + 1) @(posedge clk);
		start <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (busy);
		start <= 1'b0;
		expected_rsp.push_back(lookup_key(item));
		sent_keys.push_back(item);
		if (sent_keys.size() > KEY_HISTORY)
			void'(sent_keys.pop_front());
	endtask

	task automatic drain_results();
		while (expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_key_extremes();
		hcw_pkg::req_t item;
		item = '0;
		send_key(item);
		item = '1;
		send_key(item);
		item = '0;
		item.font_select = 1'b1;
		send_key(item);
		item = '1;
		item.font_select = 1'b0;
		send_key(item);
		// same keys again: hits
		send_key('0);
		send_key('1);
	endtask

	// keys sharing a home near the top so the window wraps to slot 0
	task automatic test_probe_window();
		hcw_pkg::req_t chain [10];
		for (int i = 0; i < 10; i++)
			chain[i] = make_key(i[0], 8'(i * 29), 381, i + 1);
		for (int i = 0; i < 8; i++)
			send_key(chain[i]);
		// refresh the oldest two so the lru victim moves
		send_key(chain[0]);
		send_key(chain[1]);
		send_key(chain[8]);
		send_key(chain[9]);
		send_key(chain[2]);
		send_key(make_key(1'b1, 8'd255, 383, 5460));
		send_key(chain[5]);
	endtask

	task automatic test_random_mix(input int count);
		for (int n = 0; n < count; n++) begin
			if (n % 20 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 29) == 0)
				drain_results();
			send_key(pick_key());
		end
		no_gaps = 1'b0;
	endtask

	// one key per home slot leaves no slot empty afterwards
	task automatic test_fill_table();
		for (int t = 0; t < ENTRIES; t++) begin
			if (t % 48 == 0)
				no_gaps = ($urandom_range(0, 2) == 0);
			send_key(make_key(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), t,
				int'($urandom_range(0, 5460))));
		end
		no_gaps = 1'b0;
	endtask

	always @(posedge clk) begin : check_rsp
		hcw_pkg::rsp_t want;
		if (arst_n && done) begin
			if (expected_rsp.size() == 0) begin
				report_mismatch("result with no item pending, slot",
					int'(rsp.slot_index), 0);
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.hit !== want.hit)
					report_mismatch("hit", int'(rsp.hit), int'(want.hit));
				if (rsp.slot_index !== want.slot_index)
					report_mismatch("slot_index", int'(rsp.slot_index),
						int'(want.slot_index));
				if (rsp.evicted !== want.evicted)
					report_mismatch("evicted", int'(rsp.evicted), int'(want.evicted));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		use_tick = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			tag_valid[i] = 1'b0;
			tag_store[i] = '0;
			tag_age[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_key_extremes();
		test_probe_window();
		test_random_mix(60);
		drain_results();
		repeat ($urandom_range(1, 11)) @(posedge clk);
		test_fill_table();
		test_random_mix(60);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_rsp.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
